// File: rtl/core/ball_seed_color_peak_finder_macros.svh
// assertion macros for the seed finder
`ifndef BALL_SEED_COLOR_PEAK_FINDER_MACROS_SVH
`define BALL_SEED_COLOR_PEAK_FINDER_MACROS_SVH

`ifndef SYNTHESIS
// general property, checked outside reset
`define BSCPF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// same-cycle implication, checked outside reset
`define BSCPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define BSCPF_ASSERT(label, clk, rst_n, prop, msg)
`define BSCPF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/bscpf_pkg.sv
package bscpf_pkg;

    localparam int COL_W         = 10;
    localparam int ROW_W         = 9;
    localparam int PIX_W         = 8;
    localparam int MAX_WIDTH     = 640;
    localparam int IDX_W         = $clog2(MAX_WIDTH);
    localparam int NEIGHBOR_SPAN = 16;
    localparam int VEC_LEN       = 56;
    localparam int DIR_GAIN      = 40;
    localparam int LUMA_MIN      = 32;
    localparam int LUMA_MAX      = 128;
    localparam int WIDTH_RESET   = 640;

    localparam int CV1_MAX  = VEC_LEN * VEC_LEN;
    localparam int CV2_BASE = 64 * VEC_LEN;
    localparam int CV1_W    = 8;
    localparam int CV2_W    = 8;
    localparam int CV3_W    = 9;
    localparam int PROD_W   = CV1_W + CV2_W;
    localparam int CV_W     = 24;
    localparam int BEST_W   = 25;

    // divisor 2*VEC_LEN^2*LUMA_MIN = 49 << 12; the odd part goes by reciprocal
    localparam int RATING_DIV   = 2 * VEC_LEN * VEC_LEN * LUMA_MIN;
    localparam int RATING_SHIFT = 12;
    localparam int RATING_ODD   = RATING_DIV >> RATING_SHIFT;
    localparam int RATING_FRAC  = 20;
    localparam int RATING_MULT  = ((2 ** RATING_FRAC) + RATING_ODD - 1) / RATING_ODD;
    localparam int RATE_IN_W    = BEST_W - RATING_SHIFT;
    localparam int MULT_W       = $clog2(RATING_MULT + 1);
    localparam int RATE_PROD_W  = RATE_IN_W + MULT_W;
    localparam int RATING_W     = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_BORDER,
        OP_PIXEL
    } bscpf_op_e;

    typedef struct packed {
        bscpf_op_e              op;
        logic [ROW_W-1:0]       row;
        logic [ROW_W-1:0]       border_row;
        logic                   frame_start;
        logic                   row_start;
        logic                   frame_end;
        logic [COL_W-1:0]       column;
        logic [CV1_W-1:0]       cv1;
        logic [CV2_W-1:0]       cv2;
        logic [CV3_W-1:0]       cv3;
        logic [IDX_W-1:0]       idx_left;
        logic [IDX_W-1:0]       idx_center;
        logic [IDX_W-1:0]       idx_right;
    } bscpf_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEFT,
        ST_RIGHT,
        ST_DECIDE,
        ST_RATE,
        ST_EMIT
    } bscpf_state_e;

endpackage

// File: rtl/core/ball_seed_color_peak_finder.sv
// channel  | handshake              | payload
// cfg      | cfg_we                 | cfg_wdata (image_width)
// in       | in_valid / in_ready    | kind column row luma chroma_blue chroma_red
//          |                        | border_row frame_start row_start frame_end
// out      | out_valid / out_ready  | seed_column seed_row color_rating
//
// a pixel holds the back end for three border reads on the one table port and a
// decide step; frame end adds the rating multiply and the result load
// the front end drops border writes beyond the table
// a two-entry queue lets the front take transfers while the back end works
// rst_n clears the queue, sequencer, scores and image_width (640); the table is not cleared
// a waiting result stalls the back end only on the next frame end
module ball_seed_color_peak_finder
    import bscpf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COL_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [COL_W-1:0]    column,
    input  logic [ROW_W-1:0]    row,
    input  logic [PIX_W-1:0]    luma,
    input  logic [PIX_W-1:0]    chroma_blue,
    input  logic [PIX_W-1:0]    chroma_red,
    input  logic [ROW_W-1:0]    border_row,
    input  logic                frame_start,
    input  logic                row_start,
    input  logic                frame_end,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COL_W-1:0]    seed_column,
    output logic [ROW_W-1:0]    seed_row,
    output logic [RATING_W-1:0] color_rating
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    bscpf_op_t q_push_data;
    bscpf_op_t q_pop_data;

    bscpf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .column      (column),
        .row         (row),
        .luma        (luma),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .border_row  (border_row),
        .frame_start (frame_start),
        .row_start   (row_start),
        .frame_end   (frame_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    bscpf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    bscpf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seed_column  (seed_column),
        .seed_row     (seed_row),
        .color_rating (color_rating)
    );

endmodule

// File: rtl/core/bscpf_front.sv
module bscpf_front
    import bscpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [COL_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [COL_W-1:0] column,
    input  logic [ROW_W-1:0] row,
    input  logic [PIX_W-1:0] luma,
    input  logic [PIX_W-1:0] chroma_blue,
    input  logic [PIX_W-1:0] chroma_red,
    input  logic [ROW_W-1:0] border_row,
    input  logic             frame_start,
    input  logic             row_start,
    input  logic             frame_end,
    input  logic             q_full,
    output logic             q_push,
    output bscpf_op_t        q_push_data
);

    localparam int EXT_W = ((IDX_W > COL_W) ? IDX_W : COL_W) + 2;
    localparam logic signed [15:0] GAIN_S = 16'(DIR_GAIN);

    logic [COL_W-1:0]   image_width_reg;
    logic [COL_W-1:0]   image_width_next;

    logic signed [9:0]  chroma_diff;
    logic signed [9:0]  chroma_sum;
    logic signed [15:0] proj;
    logic signed [15:0] cross_prod;
    logic [14:0]        cross_mag;
    logic [11:0]        cv1_full;
    logic [11:0]        cv2_full;
    logic [6:0]         term_a;
    logic [6:0]         term_b;
    logic [13:0]        luma_prod;
    logic [EXT_W-1:0]   col_ext;
    logic [EXT_W-1:0]   width_eff;
    logic [EXT_W-1:0]   left_ext;
    logic [EXT_W-1:0]   right_ext;
    logic [EXT_W-1:0]   center_ext;
    bscpf_op_e          op_kind;
    logic               keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= COL_W'(WIDTH_RESET);
        end
        else
        begin
            image_width_reg <= image_width_next;
        end
    end

    assign image_width_next = cfg_we ? cfg_wdata : image_width_reg;

    // orange projection and closeness terms
    always_comb
    begin
        chroma_diff = $signed({2'b00, chroma_red}) - $signed({2'b00, chroma_blue});
        chroma_sum  = $signed({2'b00, chroma_red}) + $signed({2'b00, chroma_blue})
                      - 10'sd256;
        proj       = 16'(chroma_diff) * GAIN_S;
        cross_prod = 16'(chroma_sum) * GAIN_S;

        if (proj <= 16'sd0)
        begin
            cv1_full = '0;
        end
        else if (proj > 16'(CV1_MAX))
        begin
            cv1_full = 12'(CV1_MAX);
        end
        else
        begin
            cv1_full = 12'(proj);
        end

        cross_mag = (cross_prod < 16'sd0) ? 15'(-cross_prod) : 15'(cross_prod);
        if (cross_mag >= 15'(CV2_BASE))
        begin
            cv2_full = '0;
        end
        else
        begin
            cv2_full = 12'(15'(CV2_BASE) - cross_mag);
        end
    end

    // luma term
    always_comb
    begin
        term_a = (luma < PIX_W'(LUMA_MIN)) ? 7'(LUMA_MIN) + 7'(luma)
                                            : 7'(2 * LUMA_MIN);
        if (luma >= PIX_W'(LUMA_MAX))
        begin
            term_b = 7'(LUMA_MIN);
        end
        else if (luma <= PIX_W'(LUMA_MAX - LUMA_MIN))
        begin
            term_b = 7'(2 * LUMA_MIN);
        end
        else
        begin
            term_b = 7'(LUMA_MIN) + 7'(PIX_W'(LUMA_MAX) - luma);
        end
        luma_prod = 14'(term_a) * 14'(term_b);
    end

    // border lookup indexes
    always_comb
    begin
        col_ext = EXT_W'(column);

        if (image_width_reg == '0)
        begin
            width_eff = EXT_W'(1);
        end
        else if (EXT_W'(image_width_reg) > EXT_W'(MAX_WIDTH))
        begin
            width_eff = EXT_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = EXT_W'(image_width_reg);
        end

        center_ext = (col_ext >= EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH - 1) : col_ext;

        if (col_ext < EXT_W'(NEIGHBOR_SPAN))
        begin
            left_ext = '0;
        end
        else
        begin
            left_ext = col_ext - EXT_W'(NEIGHBOR_SPAN);
        end
        if (left_ext >= EXT_W'(MAX_WIDTH))
        begin
            left_ext = EXT_W'(MAX_WIDTH - 1);
        end

        right_ext = col_ext + EXT_W'(NEIGHBOR_SPAN);
        if (right_ext > width_eff - EXT_W'(1))
        begin
            right_ext = width_eff - EXT_W'(1);
        end
    end

    // out-of-range border writes are dropped at the door
    assign op_kind  = kind ? OP_PIXEL : OP_BORDER;
    assign keep     = (op_kind == OP_PIXEL) || (EXT_W'(column) < EXT_W'(MAX_WIDTH));
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && keep;

    always_comb
    begin
        q_push_data.op          = op_kind;
        q_push_data.row         = row;
        q_push_data.border_row  = border_row;
        q_push_data.frame_start = frame_start;
        q_push_data.row_start   = row_start;
        q_push_data.frame_end   = frame_end;
        q_push_data.column      = column;
        q_push_data.cv1         = cv1_full[11:4];
        q_push_data.cv2         = cv2_full[11:4];
        q_push_data.cv3         = luma_prod[12:4];
        q_push_data.idx_left    = left_ext[IDX_W-1:0];
        q_push_data.idx_center  = center_ext[IDX_W-1:0];
        q_push_data.idx_right   = right_ext[IDX_W-1:0];
    end

endmodule

// File: rtl/core/bscpf_fifo.sv
`include "ball_seed_color_peak_finder_macros.svh"

module bscpf_fifo
    import bscpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  bscpf_op_t push_data,
    input  logic      pop,
    output bscpf_op_t pop_data,
    output logic      full,
    output logic      empty
);

    bscpf_op_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    `BSCPF_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
    `BSCPF_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
    `BSCPF_ASSERT(a_ptr_count, clk, rst_n, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "queue pointers disagree with count")

endmodule

// File: rtl/core/bscpf_back.sv
`include "ball_seed_color_peak_finder_macros.svh"

module bscpf_back
    import bscpf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  bscpf_op_t           q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COL_W-1:0]    seed_column,
    output logic [ROW_W-1:0]    seed_row,
    output logic [RATING_W-1:0] color_rating
);

    bscpf_state_e state_reg;
    bscpf_state_e state_next;

    logic [ROW_W-1:0]       border_mem [MAX_WIDTH];
    logic [ROW_W-1:0]       mem_rdata_reg;
    logic                   mem_we;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_addr;

    bscpf_op_t              op_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [CV_W-1:0]        cv_reg;
    logic [ROW_W-1:0]       min_reg;
    logic [BEST_W-1:0]      sum_reg;
    logic [RATE_PROD_W-1:0] rate_prod_reg;

    logic [CV_W-1:0]        prev_score_reg;
    logic [CV_W-1:0]        prev_score_next;
    logic [BEST_W-1:0]      best_score_reg;
    logic [BEST_W-1:0]      best_score_next;
    logic [COL_W-1:0]       best_column_reg;
    logic [COL_W-1:0]       best_column_next;
    logic [ROW_W-1:0]       best_row_reg;
    logic [ROW_W-1:0]       best_row_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [COL_W-1:0]       seed_column_reg;
    logic [ROW_W-1:0]       seed_row_reg;
    logic [RATING_W-1:0]    color_rating_reg;

    logic                   take_pixel;
    logic                   emit;
    logic [ROW_W-1:0]       border_min;
    logic                   hit;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && q_data.op == OP_PIXEL)
                begin
                    state_next = ST_LEFT;
                end
            end
            ST_LEFT:   state_next = ST_RIGHT;
            ST_RIGHT:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = op_reg.frame_end ? ST_RATE : ST_IDLE;
            ST_RATE:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop    = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = q_data.idx_center;
        emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop    = !q_empty;
                mem_we   = !q_empty && q_data.op == OP_BORDER;
                mem_re   = !q_empty && q_data.op == OP_PIXEL;
                mem_addr = q_data.idx_center;
            end
            ST_LEFT:
            begin
                mem_re   = 1'b1;
                mem_addr = op_reg.idx_left;
            end
            ST_RIGHT:
            begin
                mem_re   = 1'b1;
                mem_addr = op_reg.idx_right;
            end
            ST_EMIT:
            begin
                emit = !out_valid_reg || out_ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign take_pixel = q_pop && q_data.op == OP_PIXEL;
    assign border_min = (mem_rdata_reg < min_reg) ? mem_rdata_reg : min_reg;
    assign hit        = (sum_reg >= best_score_reg) && (op_reg.row >= border_min);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            border_mem[mem_addr] <= q_data.border_row;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= border_mem[mem_addr];
        end
    end

    // score and decision state
    always_comb
    begin
        prev_score_next  = prev_score_reg;
        best_score_next  = best_score_reg;
        best_column_next = best_column_reg;
        best_row_next    = best_row_reg;
        if (take_pixel)
        begin
            if (q_data.frame_start)
            begin
                best_score_next  = '0;
                best_column_next = '0;
                best_row_next    = '0;
            end
            if (q_data.row_start)
            begin
                prev_score_next = '0;
            end
        end
        else if (state_reg == ST_DECIDE)
        begin
            if (op_reg.cv1 == '0)
            begin
                prev_score_next = '0;
            end
            else
            begin
                if (hit)
                begin
                    best_score_next  = sum_reg;
                    best_column_next = op_reg.column;
                    best_row_next    = op_reg.row;
                end
                prev_score_next = cv_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prev_score_reg  <= '0;
            best_score_reg  <= '0;
            best_column_reg <= '0;
            best_row_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_score_reg  <= prev_score_next;
            best_score_reg  <= best_score_next;
            best_column_reg <= best_column_next;
            best_row_reg    <= best_row_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (take_pixel)
        begin
            op_reg   <= q_data;
            prod_reg <= PROD_W'(q_data.cv1) * PROD_W'(q_data.cv2);
        end
        if (state_reg == ST_LEFT)
        begin
            cv_reg  <= CV_W'((PROD_W + CV3_W)'(prod_reg) * (PROD_W + CV3_W)'(op_reg.cv3));
            min_reg <= mem_rdata_reg;
        end
        if (state_reg == ST_RIGHT)
        begin
            min_reg <= border_min;
            sum_reg <= BEST_W'(cv_reg) + BEST_W'(prev_score_reg);
        end
        if (state_reg == ST_RATE)
        begin
            rate_prod_reg <= RATE_PROD_W'(best_score_reg[BEST_W-1:RATING_SHIFT])
                             * RATE_PROD_W'(RATING_MULT);
        end
        if (emit)
        begin
            seed_column_reg  <= best_column_reg;
            seed_row_reg     <= best_row_reg;
            color_rating_reg <= rate_prod_reg[RATING_FRAC +: RATING_W];
        end
    end

    assign out_valid    = out_valid_reg;
    assign seed_column  = seed_column_reg;
    assign seed_row     = seed_row_reg;
    assign color_rating = color_rating_reg;

    `BSCPF_ASSERT(a_zero_clears, clk, rst_n, (state_reg == ST_DECIDE && op_reg.cv1 == '0) |=> (prev_score_reg == '0), "zero projection left neighbour score set")
    `BSCPF_ASSERT(a_result_from_emit, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT), "result raised outside emit")
    `BSCPF_ASSERT(a_plain_pixel_done, clk, rst_n, (state_reg == ST_DECIDE && !op_reg.frame_end) |=> (state_reg == ST_IDLE), "pixel without frame end did not finish")

endmodule
